// ===== src/tds_pkg.sv =====
`default_nettype none
package tds_pkg;

  localparam int MaxRows  = 64;
  localparam int FracBits = 16;
  localparam int IdxW     = $clog2(MaxRows);
  localparam int CntW     = $clog2(MaxRows + 1);

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_ZERO    = 2'd1;
  localparam logic [1:0] ERR_ROWS    = 2'd2;
  localparam logic [1:0] ERR_SAT     = 2'd3;

  localparam logic signed [63:0] FxMax = 64'sd2147483647;
  localparam logic signed [63:0] FxMin = -64'sd2147483648;

  // divider request and response
  typedef struct packed {
    logic               go;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
    logic               zero;
    logic               sat;
  } div_rsp_t;

  // clamp a wide value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > FxMax) r = 32'sh7fffffff;
    else if (v < FxMin) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > FxMax) || (v < FxMin);
  endfunction

endpackage
`default_nettype wire

// ===== src/tds_divider.sv =====
`default_nettype none
// Radix-2 restoring divider: (num << FracBits) / den, truncated toward zero.
module tds_divider import tds_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int DW = 32 + FracBits;
  localparam int SW = $clog2(DW + 1);

  logic [DW-1:0] dividend;
  logic [DW-1:0] quo;
  logic [32:0]   remain;
  logic [31:0]   divisor;
  logic          neg;
  logic          zero;
  logic          busy;
  logic          done;
  logic [SW-1:0] steps;
  logic [32:0]   trial;
  logic [DW:0]   sq;

  assign trial = {remain[31:0], dividend[DW-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy     <= 1'b1;
        steps    <= SW'(DW);
        zero     <= (req.den == 32'sd0);
        neg      <= req.num[31] ^ req.den[31];
        dividend <= {(req.num[31] ? 32'(-req.num) : 32'(req.num)), {FracBits{1'b0}}};
        divisor  <= req.den[31] ? 32'(-req.den) : 32'(req.den);
        remain   <= '0;
        quo      <= '0;
      end else if (busy) begin
        // one quotient bit each cycle
        dividend <= dividend << 1;
        if (!trial[32]) begin
          remain <= trial;
          quo    <= {quo[DW-2:0], 1'b1};
        end else begin
          remain <= {remain[31:0], dividend[DW-1]};
          quo    <= {quo[DW-2:0], 1'b0};
        end
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // sign and clamp
  always_comb begin
    sq = neg ? -{1'b0, quo} : {1'b0, quo};
    rsp.done = done;
    if (zero) begin
      rsp.quo = '0;
      rsp.sat = 1'b0;
    end else begin
      rsp.quo = sat32(64'(signed'(sq)));
      rsp.sat = ovf32(64'(signed'(sq)));
    end
    rsp.zero = zero;
  end

endmodule
`default_nettype wire

// ===== src/tridiagonal_system_solver_unit.sv =====
`default_nettype none
// Tridiagonal solver (Thomas algorithm), signed Q16.16.
// Request channel: a row (lower_coef, diag_coef, upper_coef, rhs_value,
// last_row) is taken at a clock edge where start is high and busy low.
// Forward elimination runs per row. Row 0 is stored at once and busy stays
// low unless it is the last row; each later row holds busy through the
// memory reads (S_FREAD, S_READ), the divide, multiply and write-back
// (S_MUL), so a new row is taken only after the previous one is done.
// After a row with last_row set (also one dropped as one too many),
// back-substitution emits x[n-1] down to x[0], each shown for one cycle
// with result_valid high; last_result marks index 0 and busy drops with it.
// The receiver cannot stall. error_code carries the first error of the
// system seen so far: zero pivot, too many rows (extra rows are dropped),
// or saturation. Coefficients live in one memory of MaxRows 96-bit words
// (pivot, upper, rhs) read through a registered port. Reset clears the
// sequencer, row count and error flags; memory contents are not cleared
// and are only read once written.
module tridiagonal_system_solver_unit import tds_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] lower_coef,
  input  wire logic signed [31:0] diag_coef,
  input  wire logic signed [31:0] upper_coef,
  input  wire logic signed [31:0] rhs_value,
  input  wire logic               last_row,
  output logic                    result_valid,
  output logic signed [31:0]      solution_value,
  output logic [IdxW-1:0]         solution_index,
  output logic                    last_result,
  output logic [1:0]              error_code
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FREAD = 10'b0000000010,
    S_READ  = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_SUB   = 10'b0000100000,
    S_BREAD = 10'b0001000000,
    S_BMUL  = 10'b0010000000,
    S_BNUM  = 10'b0100000000,
    S_BDIV  = 10'b1000000000
  } state_t;

  state_t state;
  logic [CntW-1:0] row_count;
  logic [IdxW-1:0] idx;
  logic [1:0] error_flags;
  logic signed [31:0] next_solution;
  logic first_back;
  logic pend_last;

  // row memory: pivot, upper, rhs
  logic [95:0] mem [MaxRows];
  logic [95:0] rd_data;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  logic [95:0] wr_data;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic signed [31:0] rd_piv, rd_up, rd_rhs;
  assign rd_piv = rd_data[95:64];
  assign rd_up  = rd_data[63:32];
  assign rd_rhs = rd_data[31:0];

  // held row
  logic signed [31:0] r_lower, r_diag, r_upper, r_rhs;
  logic signed [31:0] prev_piv, prev_up, prev_rhs;
  logic signed [63:0] prod_a, prod_b;

  div_req_t dreq;
  div_rsp_t drsp;
  tds_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  function automatic logic signed [63:0] shr_floor(input logic signed [63:0] p);
    return p >>> FracBits;
  endfunction

  logic signed [63:0] ma, mb, da, db;
  logic signed [31:0] sa, sb;

  assign ma = shr_floor(prod_a);
  assign mb = shr_floor(prod_b);
  assign sa = sat32(ma);
  assign sb = sat32(mb);
  assign da = 64'(r_diag) - 64'(sa);
  assign db = 64'(r_rhs) - 64'(sb);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    logic [1:0] err_now;
    if (rst) begin
      state        <= S_IDLE;
      row_count    <= '0;
      error_flags  <= ERR_OK;
      result_valid <= 1'b0;
      dreq.go      <= 1'b0;
      wr_en        <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      dreq.go      <= 1'b0;
      wr_en        <= 1'b0;
      err_now = error_flags;
      case (state)
        S_IDLE: begin
          if (start) begin
            r_lower <= lower_coef; r_diag <= diag_coef;
            r_upper <= upper_coef; r_rhs  <= rhs_value;
            pend_last <= last_row;
            if (row_count >= CntW'(MaxRows)) begin
              if (err_now == ERR_OK) err_now = ERR_ROWS;
              if (last_row) begin
                idx <= IdxW'(row_count - CntW'(1));
                rd_addr <= IdxW'(row_count - CntW'(1));
                first_back <= 1'b1;
                state <= S_BREAD;
              end
            end else if (row_count == '0) begin
              wr_en <= 1'b1; wr_addr <= '0;
              wr_data <= {diag_coef, upper_coef, rhs_value};
              row_count <= CntW'(1);
              // let the write land before the back pass reads it
              if (last_row) state <= S_SUB;
            end else begin
              rd_addr <= IdxW'(row_count - CntW'(1));
              state <= S_FREAD;
            end
          end
        end
        S_FREAD: begin
          // previous row arrives on rd_data at the end of this cycle
          state <= S_READ;
        end
        S_READ: begin
          prev_piv <= rd_piv; prev_up <= rd_up; prev_rhs <= rd_rhs;
          dreq.num <= r_lower; dreq.den <= rd_piv; dreq.go <= 1'b1;
          state <= S_DIV;
        end
        S_DIV: begin
          if (drsp.done) begin
            if (drsp.zero && err_now == ERR_OK) err_now = ERR_ZERO;
            if (drsp.sat && err_now == ERR_OK) err_now = ERR_SAT;
            prod_a <= 64'(drsp.quo) * 64'(prev_up);
            prod_b <= 64'(drsp.quo) * 64'(prev_rhs);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // error order: product a, diff a, product b, diff b
          if ((ovf32(ma) || ovf32(da) || ovf32(mb) || ovf32(db)) && err_now == ERR_OK)
            err_now = ERR_SAT;
          wr_en <= 1'b1; wr_addr <= IdxW'(row_count);
          wr_data <= {sat32(da), r_upper, sat32(db)};
          row_count <= row_count + CntW'(1);
          state <= S_SUB;
        end
        S_SUB: begin
          if (pend_last) begin
            idx <= IdxW'(row_count - CntW'(1));
            rd_addr <= IdxW'(row_count - CntW'(1));
            first_back <= 1'b1;
            state <= S_BREAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_BREAD: begin
          // rd_data is registered and valid in the cycle after the address
          state <= S_BMUL;
        end
        S_BMUL: begin
          prev_piv <= rd_piv;
          prev_rhs <= rd_rhs;
          prod_a <= 64'(rd_up) * 64'(next_solution);
          if (first_back) begin
            dreq.num <= rd_rhs; dreq.den <= rd_piv; dreq.go <= 1'b1;
            state <= S_BDIV;
          end else begin
            state <= S_BNUM;
          end
        end
        S_BNUM: begin
          // numerator from the registered product
          if ((ovf32(ma) || ovf32(64'(prev_rhs) - 64'(sa))) && err_now == ERR_OK)
            err_now = ERR_SAT;
          dreq.num <= sat32(64'(prev_rhs) - 64'(sa));
          dreq.den <= prev_piv; dreq.go <= 1'b1;
          state <= S_BDIV;
        end
        S_BDIV: begin
          if (drsp.done) begin
            if (drsp.zero && err_now == ERR_OK) err_now = ERR_ZERO;
            if (drsp.sat && err_now == ERR_OK) err_now = ERR_SAT;
            next_solution  <= drsp.quo;
            result_valid   <= 1'b1;
            solution_value <= drsp.quo;
            solution_index <= idx;
            last_result    <= (idx == '0);
            error_code     <= err_now;
            if (idx == '0) begin
              err_now = ERR_OK;
              row_count <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx - IdxW'(1);
              rd_addr <= idx - IdxW'(1);
              first_back <= 1'b0;
              state <= S_BREAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      error_flags <= err_now;
    end
  end

`ifndef SYNTHESIS
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !busy) else $error("busy while idle");
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_BDIV)) else $error("result outside back pass");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |-> (state == S_IDLE && row_count == '0))
    else $error("run not closed");
  a_rows: assert property (@(posedge clk) disable iff (rst)
    row_count <= CntW'(MaxRows)) else $error("row count overflow");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_tridiagonal_system_solver_unit.sv =====
`timescale 1ns / 1ps
module tb_tridiagonal_system_solver_unit;
  import tds_pkg::*;

  // solution entry as seen on the result ports
  typedef struct {
    logic signed [31:0] value;
    logic [IdxW-1:0]    index;
    logic               last;
    logic [1:0]         code;
  } solution_t;

  // Thomas-algorithm predictor with its own copy of the row stores
  class thomas_scoreboard;
    logic signed [63:0] pivots[MaxRows];
    logic signed [63:0] uppers[MaxRows];
    logic signed [63:0] rhss[MaxRows];
    int                 rows_held;
    logic signed [63:0] prev_x;
    logic [1:0]         sticky_code;
    solution_t          pending[$];
    int                 mismatches;

    function new();
      rows_held = 0;
      prev_x = 0;
      sticky_code = ERR_OK;
      mismatches = 0;
    endfunction

    function void flag(logic [1:0] c);
      if (sticky_code == ERR_OK) sticky_code = c;
    endfunction

    function logic signed [63:0] clamp(logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > FxMax) begin
        flag(ERR_SAT);
        r = FxMax;
      end else if (v < FxMin) begin
        flag(ERR_SAT);
        r = FxMin;
      end
      return r;
    endfunction

    // arithmetic shift floors toward minus infinity
    function logic signed [63:0] fmul(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b;
      return clamp(p >>> FracBits);
    endfunction

    function logic signed [63:0] fdiv(logic signed [63:0] n, logic signed [63:0] d);
      logic signed [63:0] q;
      if (d == 0) begin
        flag(ERR_ZERO);
        return 0;
      end
      q = (n * 64'sd65536) / d;
      return clamp(q);
    endfunction

    // note one accepted request row
    function void note_row(logic signed [31:0] lo, logic signed [31:0] dg,
                           logic signed [31:0] up, logic signed [31:0] rh, logic lst);
      logic signed [63:0] m, num, x;
      int r;
      solution_t s;
      if (rows_held >= MaxRows) flag(ERR_ROWS);
      else begin
        r = rows_held;
        if (r == 0) begin
          pivots[0] = dg;
          rhss[0] = rh;
        end else begin
          m = fdiv(lo, pivots[r-1]);
          pivots[r] = clamp(64'(dg) - fmul(m, uppers[r-1]));
          rhss[r] = clamp(64'(rh) - fmul(m, rhss[r-1]));
        end
        uppers[r] = up;
        rows_held = r + 1;
      end
      if (!lst) return;
      for (int i = rows_held - 1; i >= 0; i--) begin
        if (i == rows_held - 1) x = fdiv(rhss[i], pivots[i]);
        else begin
          num = clamp(rhss[i] - fmul(uppers[i], prev_x));
          x = fdiv(num, pivots[i]);
        end
        prev_x = x;
        s.value = x[31:0];
        s.index = i[IdxW-1:0];
        s.last = (i == 0);
        s.code = sticky_code;
        pending.push_back(s);
      end
      rows_held = 0;
      sticky_code = ERR_OK;
    endfunction

    // compare one result with the oldest expectation
    function void check_result(solution_t got);
      solution_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h index %0d", got.value, got.index);
        return;
      end
      e = pending.pop_front();
      if (got.value !== e.value || got.index !== e.index || got.last !== e.last ||
          got.code !== e.code) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp v=%h i=%0d l=%b c=%0d got v=%h i=%0d l=%b c=%0d",
                   e.value, e.index, e.last, e.code,
                   got.value, got.index, got.last, got.code);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0, last_row = 0;
  logic signed [31:0] lower_coef = 0, diag_coef = 0, upper_coef = 0, rhs_value = 0;
  logic busy, result_valid, last_result;
  logic signed [31:0] solution_value;
  logic [IdxW-1:0] solution_index;
  logic [1:0] error_code;

  thomas_scoreboard sb = new();
  int stall_cycles = 0;
  int sent = 0;

  tridiagonal_system_solver_unit dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    solution_t g;
    if (!rst && result_valid) begin
      g.value = solution_value;
      g.index = solution_index;
      g.last = last_result;
      g.code = error_code;
      sb.check_result(g);
    end
    if (!rst && ((start && !busy) || result_valid)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles > 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk);
  endtask

  // drive one request row and wait for it to be taken
  task automatic send_row(logic signed [31:0] lo, logic signed [31:0] dg,
                          logic signed [31:0] up, logic signed [31:0] rh, logic lst);
    lower_coef = lo;
    diag_coef = dg;
    upper_coef = up;
    rhs_value = rh;
    last_row = lst;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_row(lo, dg, up, rh, lst);
    sent++;
    @(negedge clk);
    start = 0;
    idle_gap();
  endtask

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3: return 0;
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  // well-conditioned system of n rows, diagonally dominant
  task automatic send_system(int n);
    logic signed [31:0] d;
    for (int i = 0; i < n; i++) begin
      d = $signed($urandom_range(32'h40000, 32'h80000));
      if ($urandom_range(0, 1)) d = -d;
      send_row($signed($urandom_range(0, 32'h20000)) - 32'sh10000, d,
               $signed($urandom_range(0, 32'h20000)) - 32'sh10000,
               $signed($urandom_range(0, 32'h100000)) - 32'sh80000, i == n - 1);
    end
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: single row, zero pivots, extremes, saturation
    send_row(0, 32'sh10000, 0, 32'sh30000, 1);
    send_row(0, 0, 0, 32'sh10000, 1);
    send_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0);
    send_row(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1);
    send_row(32'sh10000, 32'sh100, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_row(32'sh7fffffff, 32'sh1, 0, 32'sh80000000, 1);
    send_row(32'sh10000, 0, 32'sh10000, 32'sh10000, 0);
    send_row(32'sh10000, 32'sh20000, 0, 32'sh10000, 1);
    send_row(-1, -1, -1, -1, 0);
    send_row(-1, -1, -1, -1, 1);
    send_system(3);
    // overflow of the row store: extra rows dropped, last one still solves
    for (int i = 0; i < MaxRows + 2; i++)
      send_row($urandom_range(0, 32'hffff), 32'sh40000, $urandom_range(0, 32'hffff),
               $urandom(), i == MaxRows + 1);

    // random: mostly well-formed small systems, some raw noise, rare full size
    while (sent < 370) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            send_row(rnd_word(), rnd_word(), rnd_word(), rnd_word(), i == n - 1);
        end
        2: if ($urandom_range(0, 7) == 0) send_system(MaxRows);
           else send_system($urandom_range(8, 16));
        default: send_system($urandom_range(1, 6));
      endcase
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
